/* hdl/mvcs_pkg.sv */
// ----------------------------------------------------------------------------
// mvcs_pkg
// Types, codes and helpers shared by the move/verify/correct sequencer.
// ----------------------------------------------------------------------------
package mvcs_pkg;

    localparam int POS_W = 32;
    localparam int SPD_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // opcodes
    localparam logic [2:0] OP_MOVE   = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_CANCEL = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_FAULT  = 3'd4;

    // axis modes
    localparam logic [1:0] MODE_OPEN        = 2'd0;
    localparam logic [1:0] MODE_SUPERVISE   = 2'd1;
    localparam logic [1:0] MODE_CLOSED_LOOP = 2'd2;

    // health codes
    localparam logic [1:0] H_OK       = 2'd0;
    localparam logic [1:0] H_DEGRADED = 2'd1;
    localparam logic [1:0] H_FAULT    = 2'd2;

    // motor command kinds
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_ABS  = 2'd1;
    localparam logic [1:0] CMD_REL  = 2'd2;

    // last move direction
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_READY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH_STEPS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_TOLERANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVERGENCE_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_SPEED = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_RUN    = 2'd1,
        ST_VERIFY = 2'd2,
        ST_CORR   = 2'd3
    } stage_t;

    typedef struct packed {
        logic [2:0]              opcode;
        logic signed [POS_W-1:0] target;
        logic                    is_absolute;
        logic [SPD_W-1:0]        speed;
        logic signed [POS_W-1:0] commanded_pos;
        logic signed [POS_W-1:0] measured_pos;
        logic                    motor_moving;
    } in_word_t;

    typedef struct packed {
        logic [1:0]              cmd_kind;
        logic signed [POS_W-1:0] cmd_position;
        logic [SPD_W-1:0]        cmd_speed;
        logic                    stop_motor;
        logic                    adopt_position;
        logic                    divergence_alert;
        logic                    move_refused;
        logic [1:0]              health;
        logic [1:0]              job_stage;
    } out_word_t;

    typedef struct packed {
        logic [1:0]       axis_mode;
        logic             feedback_ready;
        logic [15:0]      backlash_steps;
        logic [15:0]      verify_tolerance;
        logic [15:0]      divergence_limit;
        logic [2:0]       max_retries;
        logic [15:0]      correction_limit;
        logic [SPD_W-1:0] correction_speed;
    } cfg_t;

    // clamp a one-bit-grown sum back to position width
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1])
            r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic [POS_W:0] mag(input logic signed [POS_W:0] v);
        logic [POS_W:0] r;
        r = v[POS_W] ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage

/* hdl/mvcs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mvcs_cfg_regs
// Configuration register file with write-only port and reset defaults.
// ----------------------------------------------------------------------------
module mvcs_cfg_regs
    import mvcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_mode        <= MODE_SUPERVISE;
            cfg_reg.feedback_ready   <= 1'b0;
            cfg_reg.backlash_steps   <= 16'd0;
            cfg_reg.verify_tolerance <= 16'd4;
            cfg_reg.divergence_limit <= 16'd20;
            cfg_reg.max_retries      <= 3'd2;
            cfg_reg.correction_limit <= 16'd5000;
            cfg_reg.correction_speed <= 20'd2000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_AXIS_MODE:        cfg_reg.axis_mode        <= cfg_data[1:0];
                CFG_FEEDBACK_READY:   cfg_reg.feedback_ready   <= cfg_data[0];
                CFG_BACKLASH_STEPS:   cfg_reg.backlash_steps   <= cfg_data[15:0];
                CFG_VERIFY_TOLERANCE: cfg_reg.verify_tolerance <= cfg_data[15:0];
                CFG_DIVERGENCE_LIMIT: cfg_reg.divergence_limit <= cfg_data[15:0];
                CFG_MAX_RETRIES:      cfg_reg.max_retries      <= cfg_data[2:0];
                CFG_CORRECTION_LIMIT: cfg_reg.correction_limit <= cfg_data[15:0];
                CFG_CORRECTION_SPEED: cfg_reg.correction_speed <= cfg_data[SPD_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/mvcs_core.sv */
// ----------------------------------------------------------------------------
// mvcs_core
// Job state machine: evaluates one word against the job state and updates it.
// ----------------------------------------------------------------------------
module mvcs_core
    import mvcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_word_t  item,
    input  cfg_t      cfg,
    output out_word_t result
);

    stage_t                  stage_reg, stage_next;
    logic signed [POS_W-1:0] job_target_reg, job_target_next;
    logic [2:0]              retries_reg, retries_next;
    logic [1:0]              last_dir_reg, last_dir_next;
    logic                    rev_flag_reg, rev_flag_next;
    logic [1:0]              health_reg, health_next;

    // move datapath
    logic signed [POS_W-1:0] meas;
    logic signed [POS_W:0]   rel_sum;
    logic signed [POS_W-1:0] abst;
    logic [1:0]              move_mode;
    logic                    dir_up, dir_dn, rev;
    logic signed [POS_W:0]   ff_sum;
    logic signed [POS_W-1:0] olt;

    // tick datapath
    logic signed [POS_W:0]   mon_diff, err;
    logic [POS_W:0]          mon_mag, err_mag;
    logic [16:0]             tol;
    logic signed [POS_W:0]   lim_pos, lim_neg;
    logic signed [POS_W-1:0] corr;

    always_comb
    begin
        meas      = cfg.feedback_ready ? item.measured_pos : item.commanded_pos;
        rel_sum   = {item.commanded_pos[POS_W-1], item.commanded_pos}
                  + {item.target[POS_W-1], item.target};
        abst      = item.is_absolute ? item.target : sat_pos(rel_sum);
        move_mode = cfg.feedback_ready ? cfg.axis_mode : MODE_OPEN;
        dir_up    = abst > item.commanded_pos;
        dir_dn    = abst < item.commanded_pos;
        rev       = (move_mode == MODE_CLOSED_LOOP) && (cfg.backlash_steps != 16'd0)
                  && ((dir_up && last_dir_reg == DIR_DOWN) || (dir_dn && last_dir_reg == DIR_UP));
        ff_sum    = dir_up ? ({abst[POS_W-1], abst} + $signed({17'd0, cfg.backlash_steps}))
                           : ({abst[POS_W-1], abst} - $signed({17'd0, cfg.backlash_steps}));
        olt       = rev ? sat_pos(ff_sum) : abst;

        mon_diff  = {meas[POS_W-1], meas} - {item.commanded_pos[POS_W-1], item.commanded_pos};
        mon_mag   = mag(mon_diff);
        err       = {job_target_reg[POS_W-1], job_target_reg} - {meas[POS_W-1], meas};
        err_mag   = mag(err);
        tol       = {1'b0, cfg.verify_tolerance}
                  + (rev_flag_reg ? {1'b0, cfg.backlash_steps} : 17'd0);
        lim_pos   = $signed({17'd0, cfg.correction_limit});
        lim_neg   = -lim_pos;
        if (err > lim_pos)
            corr = lim_pos[POS_W-1:0];
        else if (err < lim_neg)
            corr = lim_neg[POS_W-1:0];
        else
            corr = err[POS_W-1:0];
    end

    always_comb
    begin
        stage_next      = stage_reg;
        job_target_next = job_target_reg;
        retries_next    = retries_reg;
        last_dir_next   = last_dir_reg;
        rev_flag_next   = rev_flag_reg;
        health_next     = health_reg;
        result          = '0;

        unique case (item.opcode)
            OP_MOVE:
            begin
                if (health_reg == H_FAULT)
                    result.move_refused = 1'b1;
                else if (move_mode == MODE_SUPERVISE || move_mode == MODE_CLOSED_LOOP)
                begin
                    job_target_next = abst;
                    if (move_mode == MODE_CLOSED_LOOP)
                        retries_next = cfg.max_retries;
                    rev_flag_next = rev;
                    if (dir_up)
                        last_dir_next = DIR_UP;
                    else if (dir_dn)
                        last_dir_next = DIR_DOWN;
                    result.cmd_kind     = CMD_ABS;
                    result.cmd_position = olt;
                    result.cmd_speed    = item.speed;
                    stage_next          = ST_RUN;
                end
                else
                begin
                    result.cmd_kind     = item.is_absolute ? CMD_ABS : CMD_REL;
                    result.cmd_position = item.target;
                    result.cmd_speed    = item.speed;
                    stage_next          = ST_IDLE;
                end
            end
            OP_TICK:
            begin
                if (health_reg != H_FAULT)
                begin
                    unique case (stage_reg)
                        ST_RUN:
                        begin
                            if (!item.motor_moving)
                            begin
                                if (cfg.axis_mode == MODE_SUPERVISE)
                                begin
                                    if (mon_mag > {17'd0, cfg.divergence_limit})
                                    begin
                                        health_next             = H_DEGRADED;
                                        result.divergence_alert = 1'b1;
                                    end
                                    stage_next = ST_IDLE;
                                end
                                else
                                    stage_next = ST_VERIFY;
                            end
                        end
                        ST_VERIFY:
                        begin
                            if (err_mag <= {16'd0, tol})
                            begin
                                result.adopt_position = cfg.feedback_ready;
                                stage_next            = ST_IDLE;
                                rev_flag_next         = 1'b0;
                            end
                            else if (retries_reg == 3'd0)
                            begin
                                health_next             = H_DEGRADED;
                                result.divergence_alert = 1'b1;
                                result.adopt_position   = cfg.feedback_ready;
                                stage_next              = ST_IDLE;
                                rev_flag_next           = 1'b0;
                            end
                            else
                            begin
                                retries_next        = retries_reg - 3'd1;
                                result.cmd_kind     = CMD_REL;
                                result.cmd_position = corr;
                                result.cmd_speed    = cfg.correction_speed;
                                stage_next          = ST_CORR;
                            end
                        end
                        ST_CORR:
                        begin
                            if (!item.motor_moving)
                                stage_next = ST_VERIFY;
                        end
                        default:
                        begin
                            stage_next = stage_reg;
                        end
                    endcase
                end
            end
            OP_CANCEL:
            begin
                stage_next        = ST_IDLE;
                result.stop_motor = 1'b1;
            end
            OP_CLEAR:
            begin
                stage_next  = ST_IDLE;
                health_next = H_OK;
            end
            OP_FAULT:
            begin
                stage_next        = ST_IDLE;
                health_next       = H_FAULT;
                result.stop_motor = 1'b1;
            end
            default:
            begin
                stage_next = stage_reg;
            end
        endcase

        result.health    = health_next;
        result.job_stage = stage_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= ST_IDLE;
            job_target_reg <= '0;
            retries_reg    <= 3'd0;
            last_dir_reg   <= DIR_NONE;
            rev_flag_reg   <= 1'b0;
            health_reg     <= H_OK;
        end
        else if (advance)
        begin
            stage_reg      <= stage_next;
            job_target_reg <= job_target_next;
            retries_reg    <= retries_next;
            last_dir_reg   <= last_dir_next;
            rev_flag_reg   <= rev_flag_next;
            health_reg     <= health_next;
        end
    end

endmodule

/* hdl/move_verify_correct_sequencer.sv */
// ----------------------------------------------------------------------------
// move_verify_correct_sequencer
// Move-job sequencer for one encoder-equipped stepper axis.
// ----------------------------------------------------------------------------
// Takes one word per clock unless stalled and returns exactly one result word
// per input word. A word is captured in the input register, evaluated
// combinationally against the job state and written to the result register,
// so the block sustains one word per clock while the output is not stalled.
// The job state registers update on the same edge that writes the result
// register; that evaluation sets the pace. Output stall holds the result
// register; the input register keeps taking a word as long as the result
// register is free or being drained in the same cycle.
module move_verify_correct_sequencer
    import mvcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word
);

    cfg_t      cfg;
    in_word_t  in_word_reg;
    logic      in_vld_reg;
    out_word_t out_word_reg;
    logic      out_vld_reg;
    out_word_t result;
    logic      advance;

    mvcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mvcs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_word_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_word_reg <= in_word;
        if (advance)
            out_word_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_word  = out_word_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg))
        else $error("input stalled without a pending word");

    a_refused_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.move_refused) |-> (out_word.health == H_FAULT))
        else $error("move refused while health not faulted");

    a_no_cmd_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.cmd_kind == CMD_NONE)
        |-> (out_word.cmd_position == '0 && out_word.cmd_speed == '0))
        else $error("empty command carries a payload");

    a_stop_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.stop_motor || out_word.adopt_position))
        |-> (out_word.job_stage == ST_IDLE))
        else $error("stop or adopt without returning to idle");

endmodule
